/* rtl/kpi_pkg.sv */
// Shared types and constants for the keyframe pose interpolator.
// No dependencies; imported by kpi_queue, kpi_front, kpi_back and the top level.
`timescale 1ns / 1ps
`default_nettype none
package kpi_pkg;

    localparam int DEF_MAX_NODES = 32;
    localparam int DEF_MAX_POSES = 16;
    localparam int DEF_MAX_ANIMS = 8;
    localparam int DEF_MAX_KEYS  = 16;
    localparam int DEF_FRAC_BITS = 16;

    localparam int          NCOMP      = 9;
    localparam int          KEY_W      = 21;
    localparam int          Q_DEPTH    = 2;
    localparam logic [15:0] TRIG_RESET = 16'd50;

    localparam logic [1:0] CFG_NODE_COUNT = 2'd0;
    localparam logic [1:0] CFG_POSE_COUNT = 2'd1;
    localparam logic [1:0] CFG_ANIM_COUNT = 2'd2;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_WRITE  = 2'd2,
        CMD_INTERP = 2'd3
    } t_command;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_CLEAR,
        OP_APPEND,
        OP_WRITE,
        OP_INTERP
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KRD,
        ST_KCHK,
        ST_CHK,
        ST_DIV,
        ST_RA,
        ST_RB,
        ST_DIF,
        ST_MUL,
        ST_SUM
    } t_state;

    typedef struct packed {
        t_op         op;
        logic [2:0]  anim;
        logic [15:0] key_time;
        logic [4:0]  key_pose;
        logic        key_trig;
        logic [3:0]  pose_index;
        logic [4:0]  node_index;
        logic [3:0]  component;
        logic [31:0] comp_value;
        logic [15:0] progress;
    } t_cmd;

endpackage
`default_nettype wire

/* rtl/kpi_if.sv */
// Channel interfaces: command words in, transform words out.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface kpi_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        command;
    logic [2:0]        anim_index;
    logic [15:0]       key_time;
    logic signed [4:0] key_pose;
    logic              key_trigger;
    logic [3:0]        pose_index;
    logic [4:0]        node_index;
    logic [3:0]        component;
    logic signed [31:0] comp_value;
    logic [15:0]       progress;

    modport source (output valid, command, anim_index, key_time, key_pose, key_trigger,
                    pose_index, node_index, component, comp_value, progress,
                    input ready);
    modport sink (input valid, command, anim_index, key_time, key_pose, key_trigger,
                  pose_index, node_index, component, comp_value, progress,
                  output ready);
endinterface

interface kpi_out_if;
    logic               valid;
    logic               ready;
    logic [4:0]         out_node;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] rot_x;
    logic signed [31:0] rot_y;
    logic signed [31:0] rot_z;
    logic signed [31:0] sca_x;
    logic signed [31:0] sca_y;
    logic signed [31:0] sca_z;
    logic               last_node;
    logic               trigger_passed;

    modport source (output valid, out_node, pos_x, pos_y, pos_z, rot_x, rot_y, rot_z,
                    sca_x, sca_y, sca_z, last_node, trigger_passed, input ready);
    modport sink (input valid, out_node, pos_x, pos_y, pos_z, rot_x, rot_y, rot_z,
                  sca_x, sca_y, sca_z, last_node, trigger_passed, output ready);
endinterface
`default_nettype wire

/* rtl/kpi_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module kpi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

/* rtl/kpi_queue.sv */
// Short command queue between front and back.
// Depends on kpi_pkg.
`timescale 1ns / 1ps
`default_nettype none
module kpi_queue
    import kpi_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_data,
    output logic      o_full,
    output logic      o_valid,
    output t_cmd      o_data,
    input  wire logic i_pop
);
    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW = $clog2(Q_DEPTH + 1);

    t_cmd          r_buf [Q_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == CW'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_buf[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (int'(r_wp) == Q_DEPTH - 1) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (int'(r_rp) == Q_DEPTH - 1) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_buf[r_wp] <= i_data;
        end
    end
endmodule
`default_nettype wire

/* rtl/kpi_front.sv */
// Front end: accepts command words, classifies them and queues them.
// Depends on kpi_pkg, kpi_if, kpi_queue.
`timescale 1ns / 1ps
`default_nettype none
module kpi_front
    import kpi_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES,
    parameter int MAX_POSES = DEF_MAX_POSES,
    parameter int MAX_ANIMS = DEF_MAX_ANIMS
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    kpi_in_if.sink    i_in,
    output logic      o_q_valid,
    output t_cmd      o_q_cmd,
    input  wire logic i_q_pop
);
    t_cmd cls;
    logic full;
    logic anim_ok;
    logic addr_ok;

    assign i_in.ready = !full;
    assign anim_ok    = int'(i_in.anim_index) < MAX_ANIMS;
    assign addr_ok    = (int'(i_in.pose_index) < MAX_POSES)
                     && (int'(i_in.node_index) < MAX_NODES)
                     && (int'(i_in.component) < NCOMP);

    always_comb begin
        cls.anim       = i_in.anim_index;
        cls.key_time   = i_in.key_time;
        cls.key_pose   = i_in.key_pose;
        cls.key_trig   = i_in.key_trigger;
        cls.pose_index = i_in.pose_index;
        cls.node_index = i_in.node_index;
        cls.component  = i_in.component;
        cls.comp_value = i_in.comp_value;
        cls.progress   = i_in.progress;
        unique case (t_command'(i_in.command))
            CMD_CLEAR:  cls.op = anim_ok ? OP_CLEAR : OP_NOP;
            CMD_APPEND: cls.op = anim_ok ? OP_APPEND : OP_NOP;
            CMD_WRITE:  cls.op = addr_ok ? OP_WRITE : OP_NOP;
            CMD_INTERP: cls.op = OP_INTERP;
            default:    cls.op = OP_NOP;
        endcase
    end

    kpi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in.valid),
        .i_data  (cls),
        .o_full  (full),
        .o_valid (o_q_valid),
        .o_data  (o_q_cmd),
        .i_pop   (i_q_pop)
    );
endmodule
`default_nettype wire

/* rtl/kpi_back.sv */
// Back end: key tables, pose store, key search, fraction divider, blend lanes.
// Depends on kpi_pkg, kpi_if, kpi_ram.
`timescale 1ns / 1ps
`default_nettype none
module kpi_back
    import kpi_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES,
    parameter int MAX_POSES = DEF_MAX_POSES,
    parameter int MAX_ANIMS = DEF_MAX_ANIMS,
    parameter int MAX_KEYS  = DEF_MAX_KEYS,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [5:0] i_node_count,
    input  wire logic [4:0] i_pose_count,
    input  wire logic [3:0] i_anim_count,
    input  wire logic       i_q_valid,
    input  wire t_cmd       i_q_cmd,
    output logic            o_q_pop,
    kpi_out_if.source       o_out
);
    localparam int KD   = MAX_ANIMS * MAX_KEYS;
    localparam int KAW  = (KD > 1) ? $clog2(KD) : 1;
    localparam int PD   = MAX_POSES * MAX_NODES;
    localparam int PAW  = (PD > 1) ? $clog2(PD) : 1;
    localparam int AIW  = (MAX_ANIMS > 1) ? $clog2(MAX_ANIMS) : 1;
    localparam int KCW  = $clog2(MAX_KEYS + 1);
    localparam int NCW  = $clog2(MAX_NODES + 1);
    localparam int NUMW = 16 + FRAC_BITS;
    localparam int DCW  = $clog2(NUMW + 1);
    localparam int HIW  = NUMW - FRAC_BITS;
    localparam int PHW  = 33 + HIW;
    localparam int PLW  = 33 + FRAC_BITS;
    localparam int MW   = PHW + 1;
    localparam int RW   = MW + 2;

    t_state             r_state, n_state;
    t_cmd               r_cmd, n_cmd;
    logic [KCW-1:0]     r_k, n_k;
    logic [KCW-1:0]     r_n, n_n;
    logic [15:0]        r_prev_t, n_prev_t;
    logic [4:0]         r_prev_p, n_prev_p;
    logic [15:0]        r_cur_t, n_cur_t;
    logic [4:0]         r_cur_p, n_cur_p;
    logic [15:0]        r_dur, n_dur;
    logic [15:0]        r_rem, n_rem;
    logic [NUMW-1:0]    r_q, n_q;
    logic [DCW-1:0]     r_cnt, n_cnt;
    logic               r_fneg, n_fneg;
    logic [NUMW-1:0]    r_fmag, n_fmag;
    logic               r_trig, n_trig;
    logic [NCW-1:0]     r_nd, n_nd;
    logic [NCW-1:0]     r_nodes, n_nodes;
    logic [KCW-1:0]     r_kc [MAX_ANIMS];
    logic [KCW-1:0]     n_kc [MAX_ANIMS];
    logic [15:0]        r_tt [MAX_ANIMS];
    logic [15:0]        n_tt [MAX_ANIMS];
    logic [31:0]        r_a   [NCOMP];
    logic [31:0]        n_a   [NCOMP];
    logic [32:0]        r_ud  [NCOMP];
    logic [32:0]        n_ud  [NCOMP];
    logic               r_dng [NCOMP];
    logic               n_dng [NCOMP];
    logic [PHW-1:0]     r_phi [NCOMP];
    logic [PHW-1:0]     n_phi [NCOMP];
    logic [PLW-1:0]     r_plo [NCOMP];
    logic [PLW-1:0]     n_plo [NCOMP];
    logic [31:0]        r_res [NCOMP];
    logic [31:0]        n_res [NCOMP];
    logic               r_ov, n_ov;
    logic [4:0]         r_onode, n_onode;
    logic               r_olast, n_olast;
    logic               r_otrig, n_otrig;

    logic               key_we, key_re;
    logic [KAW-1:0]     key_waddr, key_raddr;
    logic [KEY_W-1:0]   key_rdata;
    logic               pose_re;
    logic [PAW-1:0]     pose_waddr, pose_raddr;
    logic [31:0]        pose_rdata [NCOMP];
    logic [AIW-1:0]     ai;
    logic               slot_free;

    logic [15:0]        rd_t;
    logic [4:0]         rd_p;
    logic [4:0]         sel_p;
    logic [16:0]        num, dur;
    logic [15:0]        num_mag;
    logic               p1_ok, p2_ok;
    logic [16:0]        rem2;
    logic               qbit;
    logic [NCW-1:0]     clamped;
    logic [32:0]        dd    [NCOMP];
    logic [MW-1:0]      mag   [NCOMP];
    logic [RW-1:0]      sum   [NCOMP];

    assign ai        = AIW'(i_q_cmd.anim);
    assign rd_t      = key_rdata[KEY_W-1:5];
    assign rd_p      = key_rdata[4:0];
    assign slot_free = !r_ov || o_out.ready;
    assign o_q_pop   = (r_state == ST_IDLE);
    assign clamped   = (int'(i_node_count) > MAX_NODES) ? NCW'(MAX_NODES) : NCW'(i_node_count);

    assign key_we    = (r_state == ST_IDLE) && i_q_valid && (i_q_cmd.op == OP_APPEND)
                    && (int'(r_kc[ai]) < MAX_KEYS);
    assign key_waddr = KAW'(int'(i_q_cmd.anim) * MAX_KEYS + int'(r_kc[ai]));
    assign key_raddr = KAW'(int'(r_cmd.anim) * MAX_KEYS + int'(r_k));
    assign key_re    = (r_state == ST_KRD);

    assign sel_p      = (r_state == ST_RB) ? r_cur_p : r_prev_p;
    assign pose_raddr = PAW'(int'(sel_p[3:0]) * MAX_NODES + int'(r_nd));
    assign pose_waddr = PAW'(int'(i_q_cmd.pose_index) * MAX_NODES + int'(i_q_cmd.node_index));
    assign pose_re    = (r_state == ST_RA) || (r_state == ST_RB);

    assign num     = {1'b0, r_cmd.progress} - {1'b0, r_prev_t};
    assign dur     = {1'b0, r_cur_t} - {1'b0, r_prev_t};
    assign num_mag = num[16] ? 16'(-num) : num[15:0];
    assign p1_ok   = !r_prev_p[4] && ({1'b0, r_prev_p[3:0]} < i_pose_count)
                  && (int'(r_prev_p[3:0]) < MAX_POSES);
    assign p2_ok   = !r_cur_p[4] && ({1'b0, r_cur_p[3:0]} < i_pose_count)
                  && (int'(r_cur_p[3:0]) < MAX_POSES);
    assign rem2    = {r_rem, r_q[NUMW-1]};
    assign qbit    = (rem2 >= {1'b0, r_dur});

    kpi_ram #(.WIDTH(KEY_W), .DEPTH(KD)) u_keys (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_waddr),
        .i_wdata ({i_q_cmd.key_time, i_q_cmd.key_pose}),
        .i_re    (key_re),
        .i_raddr (key_raddr),
        .o_rdata (key_rdata)
    );

    for (genvar c = 0; c < NCOMP; c++) begin : g_pose
        kpi_ram #(.WIDTH(32), .DEPTH(PD)) u_pose (
            .i_clk   (i_clk),
            .i_we    ((r_state == ST_IDLE) && i_q_valid && (i_q_cmd.op == OP_WRITE)
                      && (int'(i_q_cmd.component) == c)),
            .i_waddr (pose_waddr),
            .i_wdata (i_q_cmd.comp_value),
            .i_re    (pose_re),
            .i_raddr (pose_raddr),
            .o_rdata (pose_rdata[c])
        );
    end

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_k      = r_k;
        n_n      = r_n;
        n_prev_t = r_prev_t;
        n_prev_p = r_prev_p;
        n_cur_t  = r_cur_t;
        n_cur_p  = r_cur_p;
        n_dur    = r_dur;
        n_rem    = r_rem;
        n_q      = r_q;
        n_cnt    = r_cnt;
        n_fneg   = r_fneg;
        n_fmag   = r_fmag;
        n_trig   = r_trig;
        n_nd     = r_nd;
        n_nodes  = r_nodes;
        n_kc     = r_kc;
        n_tt     = r_tt;
        n_a      = r_a;
        n_ud     = r_ud;
        n_dng    = r_dng;
        n_phi    = r_phi;
        n_plo    = r_plo;
        n_res    = r_res;
        n_ov     = (r_ov && o_out.ready) ? 1'b0 : r_ov;
        n_onode  = r_onode;
        n_olast  = r_olast;
        n_otrig  = r_otrig;
        for (int c = 0; c < NCOMP; c++) begin
            dd[c]  = {pose_rdata[c][31], pose_rdata[c]} - {r_a[c][31], r_a[c]};
            mag[c] = MW'(r_phi[c]) + MW'(r_plo[c] >> FRAC_BITS);
            sum[c] = r_dng[c] ? ({{(RW-32){r_a[c][31]}}, r_a[c]} - RW'(mag[c]))
                              : ({{(RW-32){r_a[c][31]}}, r_a[c]} + RW'(mag[c]));
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    n_cmd = i_q_cmd;
                    case (i_q_cmd.op)
                        OP_CLEAR: begin
                            n_kc[ai] = '0;
                            n_tt[ai] = TRIG_RESET;
                        end
                        OP_APPEND: begin
                            if (int'(r_kc[ai]) < MAX_KEYS) begin
                                n_kc[ai] = r_kc[ai] + 1'b1;
                                if (i_q_cmd.key_trig) begin
                                    n_tt[ai] = i_q_cmd.key_time;
                                end
                            end
                        end
                        OP_INTERP: begin
                            if (({1'b0, i_q_cmd.anim} < i_anim_count)
                                && (int'(i_q_cmd.anim) < MAX_ANIMS)
                                && (r_kc[ai] != '0)) begin
                                n_state = ST_KRD;
                                n_k     = '0;
                                n_n     = r_kc[ai];
                                n_trig  = (r_tt[ai] <= i_q_cmd.progress);
                                n_nodes = clamped;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_KRD: begin
                n_state = ST_KCHK;
            end
            ST_KCHK: begin
                n_cur_t = rd_t;
                n_cur_p = rd_p;
                if (r_k == '0) begin
                    n_prev_t = rd_t;
                    n_prev_p = rd_p;
                    if (r_n == KCW'(1)) begin
                        n_state = ST_CHK;
                    end else begin
                        n_k     = KCW'(1);
                        n_state = ST_KRD;
                    end
                end else if ((rd_t > r_cmd.progress) || (r_k == r_n - 1'b1)) begin
                    n_state = ST_CHK;
                end else begin
                    n_prev_t = rd_t;
                    n_prev_p = rd_p;
                    n_k      = r_k + 1'b1;
                    n_state  = ST_KRD;
                end
            end
            ST_CHK: begin
                n_nd = '0;
                if (!p1_ok || !p2_ok || (r_nodes == '0)) begin
                    n_state = ST_IDLE;
                end else if (dur[16] || (dur == '0)) begin
                    n_fmag  = '0;
                    n_fneg  = 1'b0;
                    n_state = ST_RA;
                end else begin
                    n_q     = {num_mag, FRAC_BITS'(0)};
                    n_rem   = '0;
                    n_dur   = dur[15:0];
                    n_fneg  = num[16];
                    n_cnt   = DCW'(NUMW);
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_cnt == '0) begin
                    n_fmag  = r_q;
                    n_state = ST_RA;
                end else begin
                    n_rem = qbit ? 16'(rem2 - {1'b0, r_dur}) : rem2[15:0];
                    n_q   = {r_q[NUMW-2:0], qbit};
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_RA: begin
                n_state = ST_RB;
            end
            ST_RB: begin
                n_a     = pose_rdata;
                n_state = ST_DIF;
            end
            ST_DIF: begin
                for (int c = 0; c < NCOMP; c++) begin
                    n_ud[c]  = dd[c][32] ? 33'(-dd[c]) : dd[c];
                    n_dng[c] = dd[c][32] != r_fneg;
                end
                n_state = ST_MUL;
            end
            ST_MUL: begin
                for (int c = 0; c < NCOMP; c++) begin
                    n_phi[c] = PHW'(r_ud[c] * r_fmag[NUMW-1:FRAC_BITS]);
                    n_plo[c] = PLW'(r_ud[c] * r_fmag[FRAC_BITS-1:0]);
                end
                n_state = ST_SUM;
            end
            ST_SUM: begin
                if (slot_free) begin
                    for (int c = 0; c < NCOMP; c++) begin
                        if (sum[c][RW-1:31] == '0 || sum[c][RW-1:31] == '1) begin
                            n_res[c] = sum[c][31:0];
                        end else if (sum[c][RW-1]) begin
                            n_res[c] = 32'h8000_0000;
                        end else begin
                            n_res[c] = 32'h7fff_ffff;
                        end
                    end
                    n_ov    = 1'b1;
                    n_onode = 5'(r_nd);
                    n_olast = (r_nd + 1'b1 == r_nodes);
                    n_otrig = r_trig;
                    if (r_nd + 1'b1 == r_nodes) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_nd    = r_nd + 1'b1;
                        n_state = ST_RA;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
            for (int i = 0; i < MAX_ANIMS; i++) begin
                r_kc[i] <= '0;
                r_tt[i] <= TRIG_RESET;
            end
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            r_kc    <= n_kc;
            r_tt    <= n_tt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_k      <= n_k;
        r_n      <= n_n;
        r_prev_t <= n_prev_t;
        r_prev_p <= n_prev_p;
        r_cur_t  <= n_cur_t;
        r_cur_p  <= n_cur_p;
        r_dur    <= n_dur;
        r_rem    <= n_rem;
        r_q      <= n_q;
        r_cnt    <= n_cnt;
        r_fneg   <= n_fneg;
        r_fmag   <= n_fmag;
        r_trig   <= n_trig;
        r_nd     <= n_nd;
        r_nodes  <= n_nodes;
        r_a      <= n_a;
        r_ud     <= n_ud;
        r_dng    <= n_dng;
        r_phi    <= n_phi;
        r_plo    <= n_plo;
        r_res    <= n_res;
        r_onode  <= n_onode;
        r_olast  <= n_olast;
        r_otrig  <= n_otrig;
    end

    assign o_out.valid          = r_ov;
    assign o_out.out_node       = r_onode;
    assign o_out.pos_x          = r_res[0];
    assign o_out.pos_y          = r_res[1];
    assign o_out.pos_z          = r_res[2];
    assign o_out.rot_x          = r_res[3];
    assign o_out.rot_y          = r_res[4];
    assign o_out.rot_z          = r_res[5];
    assign o_out.sca_x          = r_res[6];
    assign o_out.sca_y          = r_res[7];
    assign o_out.sca_z          = r_res[8];
    assign o_out.last_node      = r_olast;
    assign o_out.trigger_passed = r_otrig;

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV |-> r_dur != '0)
        else $error("divide with zero duration");
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV |-> r_rem < r_dur)
        else $error("divider remainder out of range");
    a_node_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SUM |-> r_nd < r_nodes)
        else $error("node counter past node count");
    a_kchk_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_KCHK |-> $past(r_state) == ST_KRD)
        else $error("key compare without key read");
endmodule
`default_nettype wire

/* rtl/keyframe_pose_interpolator.sv */
// Top level of the keyframe pose interpolator: config registers, front, back.
// Depends on kpi_pkg, kpi_if, kpi_front, kpi_back.
//
//  channel   | dir | handshake     | word
//  i_in      | in  | valid/ready   | command, key, pose component or interpolate request
//  o_out     | out | valid/ready   | one blended transform per node
//  i_cfg_*   | in  | write enable  | node_count, pose_count, anim_count
//
// Clear, append and write are applied by the back end in its idle state.
// Interpolate: a key read and compare per key searched, fraction division (skipped
// for zero or negative duration), then pose read, difference, multiply, sum per node.
// Reset is synchronous; key counts clear and trigger times return to 50 at once.
// A two-word queue keeps accepting words, until it is full, while the back end works or o_out stalls.
`timescale 1ns / 1ps
`default_nettype none
module keyframe_pose_interpolator
    import kpi_pkg::*;
#(
    parameter int MAX_NODES = DEF_MAX_NODES,
    parameter int MAX_POSES = DEF_MAX_POSES,
    parameter int MAX_ANIMS = DEF_MAX_ANIMS,
    parameter int MAX_KEYS  = DEF_MAX_KEYS,
    parameter int FRAC_BITS = DEF_FRAC_BITS
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_idx,
    input  wire logic [5:0] i_cfg_data,
    kpi_in_if.sink          i_in,
    kpi_out_if.source       o_out
);
    logic [5:0] r_node_count;
    logic [4:0] r_pose_count;
    logic [3:0] r_anim_count;
    logic       q_valid;
    t_cmd       q_cmd;
    logic       q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= 6'd1;
            r_pose_count <= '0;
            r_anim_count <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_NODE_COUNT: r_node_count <= i_cfg_data;
                CFG_POSE_COUNT: r_pose_count <= i_cfg_data[4:0];
                CFG_ANIM_COUNT: r_anim_count <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    kpi_front #(
        .MAX_NODES (MAX_NODES),
        .MAX_POSES (MAX_POSES),
        .MAX_ANIMS (MAX_ANIMS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_q_valid (q_valid),
        .o_q_cmd   (q_cmd),
        .i_q_pop   (q_pop)
    );

    kpi_back #(
        .MAX_NODES (MAX_NODES),
        .MAX_POSES (MAX_POSES),
        .MAX_ANIMS (MAX_ANIMS),
        .MAX_KEYS  (MAX_KEYS),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_node_count (r_node_count),
        .i_pose_count (r_pose_count),
        .i_anim_count (r_anim_count),
        .i_q_valid    (q_valid),
        .i_q_cmd      (q_cmd),
        .o_q_pop      (q_pop),
        .o_out        (o_out)
    );
endmodule
`default_nettype wire
